// ----- rtl/core/csm_pkg.sv -----
`default_nettype none
package csm_pkg;

    // Default sizes of the stores
    localparam int MAX_CIRCUITS_DEF = 64;
    localparam int MAX_JUGGLERS_DEF = 1024;
    localparam int MAX_PREFS_DEF    = 16;

    // Fixed field widths
    localparam int SKILL_W = 8;
    localparam int SCORE_W = 2 * SKILL_W + 2;
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 10;
    localparam int PREF_W  = 6;
    localparam int CID_W   = 6;
    localparam int NC_W    = 7;
    localparam int NJ_W    = 11;
    localparam int CFG_W   = NJ_W;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_CIRCUIT = 3'd0,
        CMD_LOAD_JUGGLER = 3'd1,
        CMD_ADD_PREF     = 3'd2,
        CMD_START        = 3'd3,
        CMD_QUERY        = 3'd4
    } t_cmd;

    // Configuration register indexes
    localparam logic CFG_NUM_CIRCUITS = 1'b0;
    localparam logic CFG_NUM_JUGGLERS = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/core/csm_div.sv -----
`default_nettype none
module csm_div #(
    parameter int NUM_W = 11,
    parameter int DEN_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic      [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Restoring division, one quotient bit per cycle
    assign trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ----- rtl/core/capacitated_stable_matching.sv -----
`default_nettype none
// Capacitated stable matching engine. Circuits, jugglers and stated
// preferences are loaded one per item; an added preference does a
// read-modify-write of the count memory, and a query waits for the result
// register to be free. A start item first sweeps the placement and
// member-count memories over max(MAX_JUGGLERS, MAX_CIRCUITS) addresses, while
// the capacity divider runs alongside; then each proposal costs memory access,
// plus a read of each stated preference when the fallback circuits
// are checked against the stated list, and a full circuit costs a scan of the
// placement memory at one juggler per cycle to find its weakest member.
// The start item's result comes when the whole run is done.
module capacitated_stable_matching
    import csm_pkg::*;
#(
    parameter int MAX_CIRCUITS = csm_pkg::MAX_CIRCUITS_DEF,
    parameter int MAX_JUGGLERS = csm_pkg::MAX_JUGGLERS_DEF,
    parameter int MAX_PREFS    = csm_pkg::MAX_PREFS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [csm_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [csm_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [csm_pkg::IDX_W-1:0]    i_index,
    input  wire logic [csm_pkg::SKILL_W-1:0]  i_h_skill,
    input  wire logic [csm_pkg::SKILL_W-1:0]  i_e_skill,
    input  wire logic [csm_pkg::SKILL_W-1:0]  i_p_skill,
    input  wire logic [csm_pkg::PREF_W-1:0]   i_pref_circuit,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [csm_pkg::IDX_W-1:0]    o_juggler_id,
    output logic      [csm_pkg::CID_W-1:0]    o_circuit_id,
    output logic                              o_assigned,
    output logic      [csm_pkg::SCORE_W-1:0]  o_match_score,
    output logic                              o_done_res
);
    import csm_pkg::*;

    localparam int JW    = $clog2(MAX_JUGGLERS);
    localparam int NJW   = $clog2(MAX_JUGGLERS + 1);
    localparam int CW    = $clog2(MAX_CIRCUITS);
    localparam int NCW   = $clog2(MAX_CIRCUITS + 1);
    localparam int PIW   = (MAX_PREFS > 1) ? $clog2(MAX_PREFS) : 1;
    localparam int PCW   = $clog2(MAX_PREFS + 1);
    localparam int PW    = $clog2(MAX_PREFS + MAX_CIRCUITS + 1);
    localparam int SWEEP = (MAX_JUGGLERS > MAX_CIRCUITS) ? MAX_JUGGLERS : MAX_CIRCUITS;
    localparam int SWW   = $clog2(SWEEP);
    localparam int SK3   = 3 * SKILL_W;
    localparam int PRODW = 2 * SKILL_W;

    typedef struct packed {
        logic [PW-1:0]      cursor;
        logic               placed;
        logic [CW-1:0]      circ;
        logic [SCORE_W-1:0] score;
    } t_jst;

    typedef enum logic [17:0] {
        S_IDLE   = 18'b000000000000000001,
        S_PADD   = 18'b000000000000000010,
        S_QRY    = 18'b000000000000000100,
        S_CLR    = 18'b000000000000001000,
        S_NEXT   = 18'b000000000000010000,
        S_RD     = 18'b000000000000100000,
        S_LOAD   = 18'b000000000001000000,
        S_CHOOSE = 18'b000000000010000000,
        S_PREF   = 18'b000000000100000000,
        S_XRD    = 18'b000000001000000000,
        S_XCHK   = 18'b000000010000000000,
        S_CRD    = 18'b000000100000000000,
        S_MUL    = 18'b000001000000000000,
        S_SUM    = 18'b000010000000000000,
        S_MSCAN  = 18'b000100000000000000,
        S_EVAL   = 18'b001000000000000000,
        S_EVICT  = 18'b010000000000000000,
        S_DONE   = 18'b100000000000000000
    } t_state;

    // Memories
    logic [SK3-1:0]    r_csk_mem  [MAX_CIRCUITS];
    logic [SK3-1:0]    r_jsk_mem  [MAX_JUGGLERS];
    logic [PREF_W-1:0] r_pref_mem [MAX_JUGGLERS * (2 ** PIW)];
    logic [PCW-1:0]    r_pcnt_mem [MAX_JUGGLERS];
    t_jst              r_jst_mem  [MAX_JUGGLERS];
    logic [NJW-1:0]    r_mc_mem   [MAX_CIRCUITS];

    logic [SK3-1:0]    r_csk_rd, r_jsk_rd;
    logic [PREF_W-1:0] r_pref_rd;
    logic [PCW-1:0]    r_pcnt_rd;
    t_jst              r_jst_rd;
    logic [NJW-1:0]    r_mc_rd;

    // Memory port controls
    logic              csk_we, csk_re;
    logic [CW-1:0]     csk_wa, csk_ra;
    logic              jsk_we, jsk_re;
    logic [JW-1:0]     jsk_wa, jsk_ra;
    logic              pref_we, pref_re;
    logic [JW+PIW-1:0] pref_wa, pref_ra;
    logic              pcnt_we, pcnt_re;
    logic [JW-1:0]     pcnt_wa, pcnt_ra;
    logic [PCW-1:0]    pcnt_wd;
    logic              jst_we, jst_re;
    logic [JW-1:0]     jst_wa, jst_ra;
    t_jst              jst_wd;
    logic              mc_we, mc_re;
    logic [CW-1:0]     mc_wa, mc_ra;
    logic [NJW-1:0]    mc_wd;

    // Registers
    t_state             r_state, n_state;
    logic [NC_W-1:0]    r_num_circuits;
    logic [NJ_W-1:0]    r_num_jugglers;
    logic               r_started, n_started;
    logic [JW-1:0]      r_cur, n_cur;
    logic [NJW-1:0]     r_j, n_j;
    logic [PCW-1:0]     r_cnt, n_cnt;
    logic [PW-1:0]      r_cursor, n_cursor;
    logic [SK3-1:0]     r_jsk, n_jsk;
    logic [CW-1:0]      r_c, n_c;
    logic [PCW-1:0]     r_x, n_x;
    logic [PRODW-1:0]   r_p0, r_p1, r_p2;
    logic [NJW-1:0]     r_mc, n_mc;
    logic [SCORE_W-1:0] r_s, n_s;
    logic [NJW-1:0]     r_k, n_k;
    logic               r_pv, n_pv;
    logic [JW-1:0]      r_kp, n_kp;
    logic               r_found, n_found;
    logic [JW-1:0]      r_low, n_low;
    logic [SCORE_W-1:0] r_low_s, n_low_s;
    logic [PW-1:0]      r_low_cur, n_low_cur;
    logic [SWW-1:0]     r_sw, n_sw;
    logic [IDX_W-1:0]   r_qid, n_qid;
    logic               r_qok, n_qok;
    logic [JW-1:0]      r_pidx, n_pidx;
    logic [PREF_W-1:0]  r_ppc, n_ppc;

    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_o_jid, n_o_jid;
    logic [CID_W-1:0]   r_o_cid, n_o_cid;
    logic               r_o_asg, n_o_asg;
    logic [SCORE_W-1:0] r_o_score, n_o_score;
    logic               r_o_done, n_o_done;

    // Derived values
    logic [NCW-1:0]     nc;
    logic [NJW-1:0]     nj;
    logic [NJW-1:0]     cap;
    logic               div_start, div_busy;
    logic [NJW-1:0]     div_quot;
    logic               in_xfer, out_free;
    logic [PW-1:0]      limit, q;
    logic [SCORE_W-1:0] sum;
    t_cmd               cmd;

    assign nc = (32'(r_num_circuits) > MAX_CIRCUITS) ? NCW'(MAX_CIRCUITS)
                                                      : NCW'(r_num_circuits);
    assign nj = (32'(r_num_jugglers) > MAX_JUGGLERS) ? NJW'(MAX_JUGGLERS)
                                                      : NJW'(r_num_jugglers);
    assign cap = (nc == '0) ? '0 : div_quot;

    csm_div #(
        .NUM_W (NJW),
        .DEN_W (NCW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (nj),
        .i_den   (nc),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign o_in_ready = r_state == S_IDLE;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign cmd        = t_cmd'(i_cmd);
    assign limit      = PW'(r_cnt) + PW'(nc);
    assign q          = r_cursor - PW'(r_cnt);
    assign sum        = SCORE_W'(r_p0) + SCORE_W'(r_p1) + SCORE_W'(r_p2);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_circuits <= NC_W'(1);
            r_num_jugglers <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_CIRCUITS: r_num_circuits <= i_cfg_data[NC_W-1:0];
                CFG_NUM_JUGGLERS: r_num_jugglers <= i_cfg_data[NJ_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_cur       = r_cur;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_cursor    = r_cursor;
        n_jsk       = r_jsk;
        n_c         = r_c;
        n_x         = r_x;
        n_mc        = r_mc;
        n_s         = r_s;
        n_k         = r_k;
        n_pv        = r_pv;
        n_kp        = r_kp;
        n_found     = r_found;
        n_low       = r_low;
        n_low_s     = r_low_s;
        n_low_cur   = r_low_cur;
        n_sw        = r_sw;
        n_qid       = r_qid;
        n_qok       = r_qok;
        n_pidx      = r_pidx;
        n_ppc       = r_ppc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_jid     = r_o_jid;
        n_o_cid     = r_o_cid;
        n_o_asg     = r_o_asg;
        n_o_score   = r_o_score;
        n_o_done    = r_o_done;
        div_start   = 1'b0;

        csk_we  = 1'b0; csk_re  = 1'b0; csk_wa  = CW'(i_index); csk_ra  = r_c;
        jsk_we  = 1'b0; jsk_re  = 1'b0; jsk_wa  = JW'(i_index); jsk_ra  = r_cur;
        pref_we = 1'b0; pref_re = 1'b0;
        pref_wa = {r_pidx, PIW'(r_pcnt_rd)};
        pref_ra = {r_cur, PIW'(r_cursor)};
        pcnt_we = 1'b0; pcnt_re = 1'b0; pcnt_wa = JW'(i_index); pcnt_ra = r_cur;
        pcnt_wd = '0;
        jst_we  = 1'b0; jst_re  = 1'b0; jst_wa  = r_cur; jst_ra  = r_cur;
        jst_wd  = '0;
        mc_we   = 1'b0; mc_re   = 1'b0; mc_wa   = r_c; mc_ra   = r_c;
        mc_wd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (cmd)
                        CMD_LOAD_CIRCUIT: begin
                            csk_we = 32'(i_index) < MAX_CIRCUITS;
                        end
                        CMD_LOAD_JUGGLER: begin
                            jsk_we  = 32'(i_index) < MAX_JUGGLERS;
                            pcnt_we = 32'(i_index) < MAX_JUGGLERS;
                        end
                        CMD_ADD_PREF: begin
                            if (32'(i_index) < MAX_JUGGLERS) begin
                                pcnt_re = 1'b1;
                                pcnt_ra = JW'(i_index);
                                n_pidx  = JW'(i_index);
                                n_ppc   = i_pref_circuit;
                                n_state = S_PADD;
                            end
                        end
                        CMD_START: begin
                            div_start = 1'b1;
                            n_sw      = '0;
                            n_started = 1'b1;
                            n_state   = S_CLR;
                        end
                        CMD_QUERY: begin
                            n_qid   = i_index;
                            n_qok   = r_started && (32'(i_index) < MAX_JUGGLERS);
                            jst_re  = 1'b1;
                            jst_ra  = JW'(i_index);
                            n_state = S_QRY;
                        end
                        default: ;
                    endcase
                end
            end
            S_PADD: begin
                if (32'(r_pcnt_rd) < MAX_PREFS) begin
                    pref_we = 1'b1;
                    pcnt_we = 1'b1;
                    pcnt_wa = r_pidx;
                    pcnt_wd = r_pcnt_rd + PCW'(1);
                end
                n_state = S_IDLE;
            end
            S_QRY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_jid     = r_qid;
                    n_o_asg     = r_qok && r_jst_rd.placed;
                    n_o_cid     = n_o_asg ? CID_W'(r_jst_rd.circ) : '0;
                    n_o_score   = n_o_asg ? r_jst_rd.score : '0;
                    n_o_done    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_CLR: begin
                // Clear sweep over placement and member-count memories
                jst_we = 32'(r_sw) < MAX_JUGGLERS;
                jst_wa = r_sw[JW-1:0];
                mc_we  = 32'(r_sw) < MAX_CIRCUITS;
                mc_wa  = r_sw[CW-1:0];
                if (r_sw != SWW'(SWEEP - 1)) begin
                    n_sw = r_sw + SWW'(1);
                end else if (!div_busy) begin
                    n_j     = '0;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_j < nj) begin
                    n_cur   = r_j[JW-1:0];
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                jst_re  = 1'b1;
                pcnt_re = 1'b1;
                jsk_re  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_cnt    = r_pcnt_rd;
                n_cursor = r_jst_rd.cursor;
                n_jsk    = r_jsk_rd;
                n_state  = S_CHOOSE;
            end
            S_CHOOSE: begin
                // Next choice of the current proposer
                if (r_cursor >= limit) begin
                    n_j     = r_j + NJW'(1);
                    n_state = S_NEXT;
                end else if (r_cursor < PW'(r_cnt)) begin
                    pref_re = 1'b1;
                    n_state = S_PREF;
                end else begin
                    n_c = CW'(q);
                    n_x = '0;
                    n_state = (r_cnt == '0) ? S_CRD : S_XRD;
                end
            end
            S_PREF: begin
                if (32'(r_pref_rd) < 32'(nc)) begin
                    n_c     = CW'(r_pref_rd);
                    n_state = S_CRD;
                end else begin
                    n_cursor = r_cursor + PW'(1);
                    n_state  = S_CHOOSE;
                end
            end
            S_XRD: begin
                pref_re = 1'b1;
                pref_ra = {r_cur, r_x[PIW-1:0]};
                n_state = S_XCHK;
            end
            S_XCHK: begin
                // Fallback circuit already on the stated list is skipped
                if (32'(r_pref_rd) == 32'(r_c)) begin
                    n_cursor = r_cursor + PW'(1);
                    n_state  = S_CHOOSE;
                end else if ((r_x + PCW'(1)) == r_cnt) begin
                    n_state = S_CRD;
                end else begin
                    n_x     = r_x + PCW'(1);
                    n_state = S_XRD;
                end
            end
            S_CRD: begin
                csk_re  = 1'b1;
                mc_re   = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_mc    = r_mc_rd;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_s = sum;
                if (r_mc < cap) begin
                    jst_we  = 1'b1;
                    jst_wd  = '{cursor: r_cursor, placed: 1'b1, circ: r_c, score: sum};
                    mc_we   = 1'b1;
                    mc_wd   = r_mc + NJW'(1);
                    n_j     = r_j + NJW'(1);
                    n_state = S_NEXT;
                end else begin
                    n_k     = '0;
                    n_pv    = 1'b0;
                    n_found = 1'b0;
                    n_state = S_MSCAN;
                end
            end
            S_MSCAN: begin
                // Weakest member search, one juggler per cycle
                if (r_k < nj) begin
                    jst_re = 1'b1;
                    jst_ra = r_k[JW-1:0];
                    n_kp   = r_k[JW-1:0];
                    n_pv   = 1'b1;
                    n_k    = r_k + NJW'(1);
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && r_jst_rd.placed && r_jst_rd.circ == r_c &&
                    (!r_found || r_jst_rd.score < r_low_s)) begin
                    n_found   = 1'b1;
                    n_low     = r_kp;
                    n_low_s   = r_jst_rd.score;
                    n_low_cur = r_jst_rd.cursor;
                end
                if (r_k >= nj && !r_pv) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (cap != '0 && r_found && r_low_s < r_s) begin
                    jst_we  = 1'b1;
                    jst_wa  = r_low;
                    jst_wd  = '{cursor: r_low_cur + PW'(1), placed: 1'b0,
                                circ: '0, score: '0};
                    n_state = S_EVICT;
                end else begin
                    n_cursor = r_cursor + PW'(1);
                    n_state  = S_CHOOSE;
                end
            end
            S_EVICT: begin
                jst_we  = 1'b1;
                jst_wd  = '{cursor: r_cursor, placed: 1'b1, circ: r_c, score: r_s};
                n_cur   = r_low;
                n_state = S_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_jid     = '0;
                    n_o_cid     = '0;
                    n_o_asg     = 1'b0;
                    n_o_score   = '0;
                    n_o_done    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_j       <= n_j;
        r_cnt     <= n_cnt;
        r_cursor  <= n_cursor;
        r_jsk     <= n_jsk;
        r_c       <= n_c;
        r_x       <= n_x;
        r_mc      <= n_mc;
        r_s       <= n_s;
        r_k       <= n_k;
        r_kp      <= n_kp;
        r_found   <= n_found;
        r_low     <= n_low;
        r_low_s   <= n_low_s;
        r_low_cur <= n_low_cur;
        r_sw      <= n_sw;
        r_qid     <= n_qid;
        r_qok     <= n_qok;
        r_pidx    <= n_pidx;
        r_ppc     <= n_ppc;
        r_o_jid   <= n_o_jid;
        r_o_cid   <= n_o_cid;
        r_o_asg   <= n_o_asg;
        r_o_score <= n_o_score;
        r_o_done  <= n_o_done;
    end

    // Skill products, registered before the sum
    always_ff @(posedge i_clk) begin
        r_p0 <= r_jsk[SK3-1 -: SKILL_W] * r_csk_rd[SK3-1 -: SKILL_W];
        r_p1 <= r_jsk[2*SKILL_W-1 -: SKILL_W] * r_csk_rd[2*SKILL_W-1 -: SKILL_W];
        r_p2 <= r_jsk[SKILL_W-1:0] * r_csk_rd[SKILL_W-1:0];
    end

    // Circuit skills
    always_ff @(posedge i_clk) begin
        if (csk_we) r_csk_mem[csk_wa] <= {i_h_skill, i_e_skill, i_p_skill};
        if (csk_re) r_csk_rd <= r_csk_mem[csk_ra];
    end

    // Juggler skills
    always_ff @(posedge i_clk) begin
        if (jsk_we) r_jsk_mem[jsk_wa] <= {i_h_skill, i_e_skill, i_p_skill};
        if (jsk_re) r_jsk_rd <= r_jsk_mem[jsk_ra];
    end

    // Stated preferences
    always_ff @(posedge i_clk) begin
        if (pref_we) r_pref_mem[pref_wa] <= r_ppc;
        if (pref_re) r_pref_rd <= r_pref_mem[pref_ra];
    end

    // Stated preference counts
    always_ff @(posedge i_clk) begin
        if (pcnt_we) r_pcnt_mem[pcnt_wa] <= pcnt_wd;
        if (pcnt_re) r_pcnt_rd <= r_pcnt_mem[pcnt_ra];
    end

    // Per-juggler cursor, placement and score
    always_ff @(posedge i_clk) begin
        if (jst_we) r_jst_mem[jst_wa] <= jst_wd;
        if (jst_re) r_jst_rd <= r_jst_mem[jst_ra];
    end

    // Circuit member counts
    always_ff @(posedge i_clk) begin
        if (mc_we) r_mc_mem[mc_wa] <= mc_wd;
        if (mc_re) r_mc_rd <= r_mc_mem[mc_ra];
    end

    assign o_out_valid   = r_out_valid;
    assign o_juggler_id  = r_o_jid;
    assign o_circuit_id  = r_o_cid;
    assign o_assigned    = r_o_asg;
    assign o_match_score = r_o_score;
    assign o_done_res    = r_o_done;

endmodule
`default_nettype wire

// ----- verif/tb_capacitated_stable_matching.sv -----
`default_nettype none
module tb_capacitated_stable_matching;
    import csm_pkg::*;

    localparam int N_CIRC     = MAX_CIRCUITS_DEF;
    localparam int N_JUG      = MAX_JUGGLERS_DEF;
    localparam int N_PREF     = MAX_PREFS_DEF;
    localparam int CYCLE_CAP  = 3000000;
    localparam int SETTLE     = 64;
    localparam int NOT_SEATED = -1;
    // codes outside the command set, ignored by the block
    localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   index;
        logic [SKILL_W-1:0] h;
        logic [SKILL_W-1:0] e;
        logic [SKILL_W-1:0] p;
        logic [PREF_W-1:0]  pc;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]   jid;
        logic [CID_W-1:0]   cid;
        logic               assigned;
        logic [SCORE_W-1:0] score;
        logic               done;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_item              cur = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [IDX_W-1:0]   juggler_id;
    logic [CID_W-1:0]   circuit_id;
    logic               assigned;
    logic [SCORE_W-1:0] match_score;
    logic               done_res;

    t_item   item_q[$];
    t_answer answer_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      n_items = 0;
    int      n_answers = 0;
    int      n_starts = 0;
    bit      quiet = 0;

    // predictor state
    logic [SKILL_W-1:0] circ_sk[N_CIRC][3];
    logic [SKILL_W-1:0] jug_sk[N_JUG][3];
    int                 pref_list[N_JUG][N_PREF];
    int                 pref_cnt[N_JUG];
    int                 cursor[N_JUG];
    int                 seat[N_JUG];
    int unsigned        seat_score[N_JUG];
    int                 members[N_CIRC];
    int                 cap = 0;
    int                 reg_nc = 1;
    int                 reg_nj = 0;

    capacitated_stable_matching u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_cmd          (cur.cmd),
        .i_index        (cur.index),
        .i_h_skill      (cur.h),
        .i_e_skill      (cur.e),
        .i_p_skill      (cur.p),
        .i_pref_circuit (cur.pc),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_juggler_id   (juggler_id),
        .o_circuit_id   (circuit_id),
        .o_assigned     (assigned),
        .o_match_score  (match_score),
        .o_done_res     (done_res)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned fit_score(int j, int c);
        int unsigned s;
        s = 0;
        for (int k = 0; k < 3; k++) s += jug_sk[j][k] * circ_sk[c][k];
        return s;
    endfunction

    // circuit at choice position p, or -1 when that position is skipped
    function automatic int choice(int j, int p, int nc);
        int q;
        if (p < pref_cnt[j]) return (pref_list[j][p] < nc) ? pref_list[j][p] : -1;
        q = p - pref_cnt[j];
        if (q >= nc) return -1;
        for (int k = 0; k < pref_cnt[j]; k++)
            if (pref_list[j][k] == q) return -1;
        return q;
    endfunction

    // propose juggler j, following any chain of evictions
    function automatic void propose(int j, int nc, int nj);
        int          who, c, weakest;
        int unsigned s, low_s;
        bit          found, bumped;
        who = j;
        forever begin
            bumped = 0;
            while (cursor[who] < pref_cnt[who] + nc) begin
                c = choice(who, cursor[who], nc);
                if (c < 0) begin
                    cursor[who]++;
                    continue;
                end
                s = fit_score(who, c);
                if (members[c] < cap) begin
                    seat[who] = c;
                    seat_score[who] = s;
                    members[c]++;
                    return;
                end
                found = 0;
                weakest = 0;
                low_s = 0;
                for (int k = 0; k < nj; k++) begin
                    if (seat[k] == c && (!found || seat_score[k] < low_s)) begin
                        found = 1;
                        weakest = k;
                        low_s = seat_score[k];
                    end
                end
                if (cap != 0 && found && low_s < s) begin
                    seat[weakest] = NOT_SEATED;
                    seat_score[weakest] = 0;
                    seat[who] = c;
                    seat_score[who] = s;
                    cursor[weakest]++;
                    who = weakest;
                    bumped = 1;
                    break;
                end
                cursor[who]++;
            end
            if (!bumped) return;
        end
    endfunction

    function automatic void run_matching();
        int nc, nj;
        nc = (reg_nc > N_CIRC) ? N_CIRC : reg_nc;
        nj = (reg_nj > N_JUG) ? N_JUG : reg_nj;
        cap = (nc != 0) ? nj / nc : 0;
        for (int j = 0; j < N_JUG; j++) begin
            cursor[j] = 0;
            seat[j] = NOT_SEATED;
            seat_score[j] = 0;
        end
        for (int c = 0; c < N_CIRC; c++) members[c] = 0;
        for (int j = 0; j < nj; j++) propose(j, nc, nj);
    endfunction

    // update the predictor with one accepted transfer
    function automatic void absorb(t_item it);
        t_answer a;
        int      x;
        x = it.index;
        a = '0;
        case (it.cmd)
            CMD_LOAD_CIRCUIT: begin
                if (x < N_CIRC) begin
                    circ_sk[x][0] = it.h;
                    circ_sk[x][1] = it.e;
                    circ_sk[x][2] = it.p;
                end
            end
            CMD_LOAD_JUGGLER: begin
                jug_sk[x][0] = it.h;
                jug_sk[x][1] = it.e;
                jug_sk[x][2] = it.p;
                pref_cnt[x] = 0;
            end
            CMD_ADD_PREF: begin
                if (pref_cnt[x] < N_PREF) begin
                    pref_list[x][pref_cnt[x]] = it.pc;
                    pref_cnt[x]++;
                end
            end
            CMD_START: begin
                run_matching();
                a.done = 1'b1;
                answer_q.push_back(a);
            end
            CMD_QUERY: begin
                a.jid = it.index;
                if (seat[x] != NOT_SEATED) begin
                    a.assigned = 1'b1;
                    a.cid = seat[x];
                    a.score = seat_score[x];
                end
                answer_q.push_back(a);
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        bit    took;
        t_item nxt;
        took = in_valid && in_ready;
        if (took) begin
            absorb(cur);
            n_items++;
        end
        if (!in_valid || took) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                nxt = item_q.pop_front();
                cur <= nxt;
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int stall = 0;
    always @(posedge i_clk) begin
        t_answer want;
        if (out_valid && out_ready) begin
            n_answers++;
            if (answer_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result jid=%0d cid=%0d asg=%0d score=%0d done=%0d",
                         $time, juggler_id, circuit_id, assigned, match_score, done_res);
            end else begin
                want = answer_q.pop_front();
                if (juggler_id !== want.jid || circuit_id !== want.cid
                        || assigned !== want.assigned || match_score !== want.score
                        || done_res !== want.done) begin
                    errors++;
                    $display("%0t: mismatch expected jid=%0d cid=%0d asg=%0d score=%0d done=%0d",
                             $time, want.jid, want.cid, want.assigned, want.score, want.done);
                    $display("%0t:          actual   jid=%0d cid=%0d asg=%0d score=%0d done=%0d",
                             $time, juggler_id, circuit_id, assigned, match_score, done_res);
                end
            end
        end
        if (stall > 0) begin
            stall <= stall - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            stall <= pick_gap();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_item mk(logic [CMD_W-1:0] cmd, int idx, int h, int e, int p, int pc);
        t_item it;
        it.cmd = cmd;
        it.index = idx;
        it.h = h;
        it.e = e;
        it.p = p;
        it.pc = pc;
        return it;
    endfunction

    function automatic int rand_skill();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 255;
        return $urandom_range(255);
    endfunction

    task automatic drain();
        while (item_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        reg_nc = (idx == CFG_NUM_CIRCUITS) ? val : reg_nc;
        reg_nj = (idx == CFG_NUM_JUGGLERS) ? val : reg_nj;
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one full round: configure, load, state preferences, match, query
    task automatic round(int nc, int nj, int max_prefs, int n_rand_q, bit all_q);
        int unc, unj, k;
        drain();
        write_cfg(CFG_NUM_CIRCUITS, nc);
        write_cfg(CFG_NUM_JUGGLERS, nj);
        quiet = ($urandom_range(3) == 0);
        unc = (nc > N_CIRC) ? N_CIRC : nc;
        unj = (nj > N_JUG) ? N_JUG : nj;
        for (int c = 0; c < unc; c++)
            item_q.push_back(mk(CMD_LOAD_CIRCUIT, c, rand_skill(), rand_skill(),
                                rand_skill(), $urandom_range(63)));
        for (int j = 0; j < unj; j++) begin
            item_q.push_back(mk(CMD_LOAD_JUGGLER, j, rand_skill(), rand_skill(),
                                rand_skill(), $urandom_range(63)));
            k = $urandom_range(max_prefs);
            for (int q = 0; q < k; q++)
                item_q.push_back(mk(CMD_ADD_PREF, j, $urandom_range(255), $urandom_range(255),
                                    $urandom_range(255),
                                    ($urandom_range(7) == 0) ? $urandom_range(63)
                                                             : $urandom_range(unc + 1)));
            // noise: ignored commands and out-of-store circuit loads
            if ($urandom_range(9) == 0)
                item_q.push_back(mk($urandom_range(CMD_BAD_LO, CMD_BAD_HI), $urandom_range(1023),
                                    $urandom_range(255), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(63)));
            if ($urandom_range(14) == 0)
                item_q.push_back(mk(CMD_LOAD_CIRCUIT, $urandom_range(N_CIRC, 1023),
                                    $urandom_range(255), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(63)));
        end
        item_q.push_back(mk(CMD_START, $urandom_range(1023), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255), $urandom_range(63)));
        n_starts++;
        if (all_q)
            for (int j = 0; j < unj; j++)
                item_q.push_back(mk(CMD_QUERY, j, $urandom_range(255), 0, 0, $urandom_range(63)));
        for (int q = 0; q < n_rand_q; q++)
            item_q.push_back(mk(CMD_QUERY, ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                                    : $urandom_range(unj + 2),
                                0, $urandom_range(255), 0, 0));
    endtask

    initial begin
        int nc, nj;
        for (int j = 0; j < N_JUG; j++) begin
            pref_cnt[j] = 0;
            seat[j] = NOT_SEATED;
            seat_score[j] = 0;
            cursor[j] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: skill extremes, repeated and unused stated circuits, ignored codes
        write_cfg(CFG_NUM_CIRCUITS, 3);
        write_cfg(CFG_NUM_JUGGLERS, 4);
        item_q.push_back(mk(CMD_QUERY, 1023, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_LOAD_CIRCUIT, 0, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_LOAD_CIRCUIT, 1, 255, 255, 255, 63));
        item_q.push_back(mk(CMD_LOAD_CIRCUIT, 2, 1, 128, 255, 0));
        item_q.push_back(mk(CMD_LOAD_CIRCUIT, 100, 7, 7, 7, 0));
        item_q.push_back(mk(CMD_LOAD_JUGGLER, 0, 255, 255, 255, 0));
        item_q.push_back(mk(CMD_LOAD_JUGGLER, 1, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_LOAD_JUGGLER, 2, 128, 1, 7, 0));
        item_q.push_back(mk(CMD_LOAD_JUGGLER, 3, 255, 0, 255, 0));
        item_q.push_back(mk(CMD_ADD_PREF, 0, 0, 0, 0, 5));
        item_q.push_back(mk(CMD_ADD_PREF, 0, 0, 0, 0, 2));
        item_q.push_back(mk(CMD_ADD_PREF, 0, 0, 0, 0, 2));
        item_q.push_back(mk(CMD_ADD_PREF, 2, 0, 0, 0, 63));
        item_q.push_back(mk(CMD_ADD_PREF, 3, 0, 0, 0, 1));
        item_q.push_back(mk(CMD_BAD_LO, 5, 1, 2, 3, 4));
        item_q.push_back(mk(CMD_BAD_HI, 1023, 255, 255, 255, 63));
        item_q.push_back(mk(CMD_START, 0, 0, 0, 0, 0));
        for (int j = 0; j < 4; j++) item_q.push_back(mk(CMD_QUERY, j, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_QUERY, 512, 0, 0, 0, 0));

        // a list filled past its limit, then cleared by a reload
        drain();
        for (int q = 0; q < N_PREF + 2; q++)
            item_q.push_back(mk(CMD_ADD_PREF, 1, 0, 0, 0, q % 4));
        item_q.push_back(mk(CMD_START, 0, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_QUERY, 1, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_LOAD_JUGGLER, 1, 9, 9, 9, 0));
        item_q.push_back(mk(CMD_START, 0, 0, 0, 0, 0));
        item_q.push_back(mk(CMD_QUERY, 1, 0, 0, 0, 0));

        // no circuits, then every circuit at zero capacity with the register above bound
        round(0, 5, 3, 3, 1);
        round(127, 10, 4, 2, 1);
        // juggler register above bound: the whole store lands in one circuit
        round(1, 2047, 0, 24, 0);

        // random rounds, mostly small
        while (n_items + item_q.size() < 1500) begin
            nc = $urandom_range(1, 6);
            nj = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
            round(nc, nj, $urandom_range(1, 5), $urandom_range(4), 1);
        end

        drain();
        $display("covered %0d transfers in, %0d results out, %0d matching runs",
                 n_items, n_answers, n_starts);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
